>>> rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: word widths, action
// and status codes, and the structs passed down and along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int POS_IN_W = 5;
    localparam int COUNT_W  = 5;
    localparam int FPOS_W   = 4;

    // default list depth
    localparam int CAPACITY_DEF = 16;

    // action codes
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;

    // broadcast control for every cell
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic              srch;
        logic              rd_en;
        logic [DATA_W-1:0] data;
    } ils_ctrl_t;

    // running summary handed from cell to cell
    typedef struct packed {
        logic              has;
        logic              found;
        logic [DATA_W-1:0] max_v;
        logic [DATA_W-1:0] min_v;
        logic [DATA_W-1:0] rd;
    } ils_acc_t;

endpackage

`default_nettype wire

>>> rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an entry, shifts it to or from its neighbors on
// insert and delete, and folds its entry into the running summary word
// passed along the chain (max, min, first match, read data).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int PW  = 4
)(
    input  wire logic              clk,
    input  wire ils_ctrl_t         ctrl,
    input  wire logic [CW-1:0]     pos,
    input  wire logic [CW-1:0]     cnt,
    input  wire logic [DATA_W-1:0] left_entry,
    input  wire logic [DATA_W-1:0] right_entry,
    output logic      [DATA_W-1:0] entry,
    input  wire ils_acc_t          acc_in,
    input  wire logic [PW-1:0]     fpos_in,
    output ils_acc_t               acc_out,
    output logic      [PW-1:0]     fpos_out
);

    localparam logic [CW-1:0] IDX_W = CW'(IDX);
    localparam logic [CW-1:0] IDX_N = CW'(IDX + 1);
    localparam logic [PW-1:0] IDX_P = PW'(IDX);

    logic [DATA_W-1:0] entry_reg;
    ils_acc_t          acc_reg;
    ils_acc_t          acc_next;
    logic [PW-1:0]     fpos_reg;
    logic [PW-1:0]     fpos_next;
    logic              occ;
    logic              load;
    logic              shift_up;
    logic              shift_dn;

    // slot decode against position and count
    always_comb
    begin
        occ      = IDX_W < cnt;
        load     = ctrl.ins_en && (IDX_W == pos);
        shift_up = ctrl.ins_en && (IDX_W > pos) && (IDX_W <= cnt);
        shift_dn = ctrl.del_en && (IDX_W >= pos) && (IDX_N < cnt);
    end

    // entry storage with neighbor shifts
    always_ff @(posedge clk)
    begin
        priority if (load)
            entry_reg <= ctrl.data;
        else if (shift_up)
            entry_reg <= left_entry;
        else if (shift_dn)
            entry_reg <= right_entry;
        else
            entry_reg <= entry_reg;
    end

    // fold this entry into the summary word
    always_comb
    begin
        acc_next  = acc_in;
        fpos_next = fpos_in;
        if (occ)
        begin
            if (!acc_in.has || ($signed(entry_reg) > $signed(acc_in.max_v)))
                acc_next.max_v = entry_reg;
            if (!acc_in.has || ($signed(entry_reg) < $signed(acc_in.min_v)))
                acc_next.min_v = entry_reg;
            acc_next.has = 1'b1;
            if (ctrl.srch && !acc_in.found && (entry_reg == ctrl.data))
            begin
                acc_next.found = 1'b1;
                fpos_next      = IDX_P;
            end
            if (ctrl.rd_en && (IDX_W == pos))
                acc_next.rd = entry_reg;
        end
    end

    // summary register toward the next cell
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        fpos_reg <= fpos_next;
    end

    assign entry    = entry_reg;
    assign acc_out  = acc_reg;
    assign fpos_out = fpos_reg;

endmodule

`default_nettype wire

>>> rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of signed words kept in a row of cells. Supports
// read, insert, delete and search; every result also carries the count
// and the max and min of the list (-1 when empty).
//
//  channel  | signals                                      | handshake
//  ---------+----------------------------------------------+--------------------
//  command  | action, position, value                      | start & !busy
//  result   | status, count, read_value, found,            | done, one cycle,
//           | found_position, max_value, min_value         | cannot be held off
//
// The list is updated at the edge that accepts a command; the summary word
// then ripples one cell per cycle through the cell registers, and done rises
// once the word has reached the end of the chain. busy is low in the done
// cycle, so a new command can be taken there, but none while a scan runs.
// Reset clears the count and the control state; entries are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          action,
    input  wire logic [POS_IN_W-1:0] position,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic [1:0]               status,
    output logic [COUNT_W-1:0]       count,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     found,
    output logic [FPOS_W-1:0]        found_position,
    output logic signed [DATA_W-1:0] max_value,
    output logic signed [DATA_W-1:0] min_value
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = (IW > POS_IN_W) ? IW : POS_IN_W;

    localparam logic [IW-1:0] CAP_FULL = IW'(CAPACITY);
    localparam logic [PW-1:0] SCAN_END = PW'(CAPACITY - 1);

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [IW-1:0]     count_reg;
    logic [IW-1:0]     count_next;
    logic [PW-1:0]     scan_reg;
    logic [PW-1:0]     scan_next;
    logic [1:0]        action_reg;
    logic [CW-1:0]     pos_reg;
    logic [DATA_W-1:0] key_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_new;

    logic              accept;
    logic [CW-1:0]     pos_in_w;
    logic [CW-1:0]     cnt_w;
    ils_ctrl_t         ctrl;

    logic [DATA_W-1:0] entry_w [CAPACITY];
    ils_acc_t          acc_w   [CAPACITY + 1];
    logic [PW-1:0]     fpos_w  [CAPACITY + 1];

    logic [IW+COUNT_W-1:0] count_ext;
    logic [PW+FPOS_W-1:0]  fpos_ext;
    ils_acc_t              acc_last;

    assign accept   = start && !busy;
    assign pos_in_w = CW'(position);
    assign cnt_w    = CW'(count_reg);

    // status of an incoming command
    always_comb
    begin
        status_new = ST_OK;
        unique case (action)
            ACT_READ:
                if (pos_in_w >= cnt_w)
                    status_new = ST_BADPOS;
            ACT_INSERT:
                if (count_reg == CAP_FULL)
                    status_new = ST_FULL;
                else if (pos_in_w > cnt_w)
                    status_new = ST_BADPOS;
            ACT_DELETE:
                if (pos_in_w >= cnt_w)
                    status_new = ST_BADPOS;
            ACT_SEARCH:
                status_new = ST_OK;
            default:
                status_new = ST_OK;
        endcase
    end

    // broadcast control word
    always_comb
    begin
        ctrl.ins_en = accept && (action == ACT_INSERT) && (status_new == ST_OK);
        ctrl.del_en = accept && (action == ACT_DELETE) && (status_new == ST_OK);
        ctrl.srch   = action_reg == ACT_SEARCH;
        ctrl.rd_en  = (action_reg == ACT_READ) && (status_reg == ST_OK);
        ctrl.data   = accept ? value : key_reg;
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
            count_next = count_reg + IW'(1);
        else if (ctrl.del_en)
            count_next = count_reg - IW'(1);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            S_IDLE, S_DONE:
                if (accept)
                begin
                    state_next = S_SCAN;
                    scan_next  = '0;
                end
                else
                    state_next = S_IDLE;
            S_SCAN:
                if (scan_reg == SCAN_END)
                    state_next = S_DONE;
                else
                    scan_next = scan_reg + PW'(1);
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    // command word held for the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_READ;
            status_reg <= ST_OK;
        end
        else if (accept)
        begin
            action_reg <= action;
            status_reg <= status_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= pos_in_w;
            key_reg <= value;
        end
    end

    // chain of list cells
    assign acc_w[0]  = '{has: 1'b0, found: 1'b0, max_v: '0, min_v: '0, rd: '0};
    assign fpos_w[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_e;
        logic [DATA_W-1:0] right_e;

        if (i == 0)
        begin : g_first
            assign left_e = value;
        end
        else
        begin : g_mid_l
            assign left_e = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = entry_w[i];
        end
        else
        begin : g_mid_r
            assign right_e = entry_w[i+1];
        end

        ils_cell #(
            .IDX (i),
            .CW  (CW),
            .PW  (PW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (accept ? pos_in_w : pos_reg),
            .cnt         (cnt_w),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (entry_w[i]),
            .acc_in      (acc_w[i]),
            .fpos_in     (fpos_w[i]),
            .acc_out     (acc_w[i+1]),
            .fpos_out    (fpos_w[i+1])
        );
    end

    // result word
    assign acc_last       = acc_w[CAPACITY];
    assign count_ext      = {{COUNT_W{1'b0}}, count_reg};
    assign fpos_ext       = {{FPOS_W{1'b0}}, fpos_w[CAPACITY]};
    assign busy           = state_reg == S_SCAN;
    assign done           = state_reg == S_DONE;
    assign status         = status_reg;
    assign count          = count_ext[COUNT_W-1:0];
    assign read_value     = acc_last.rd;
    assign found          = acc_last.found;
    assign found_position = fpos_ext[FPOS_W-1:0];
    assign max_value      = acc_last.has ? acc_last.max_v : '1;
    assign min_value      = acc_last.has ? acc_last.min_v : '1;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_FULL)
        else $error("count beyond capacity");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_SCAN)
        else $error("done without scan");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + IW'(1))
        else $error("insert did not grow list");

    a_empty_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (count_reg == '0)) |-> (max_value == '1) && (min_value == '1))
        else $error("empty list extremes wrong");

    a_found_is_search: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (action_reg == ACT_SEARCH) && (status == ST_OK))
        else $error("found outside search");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed list store. Commands go in through
// the start/busy handshake in random bursts. A shadow list in the bench
// predicts each result word, and every done strobe is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ils_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_CMDS = 950;

    // one command word
    typedef struct packed {
        logic [1:0]                action;
        logic [POS_IN_W-1:0]       position;
        logic signed [DATA_W-1:0]  value;
    } list_cmd_t;

    // one result word
    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count;
        logic signed [DATA_W-1:0]  read_value;
        logic                      found;
        logic [FPOS_W-1:0]         found_position;
        logic signed [DATA_W-1:0]  max_value;
        logic signed [DATA_W-1:0]  min_value;
    } list_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                action = ACT_READ;
    logic [POS_IN_W-1:0]       position = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic                      done;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;
    logic signed [DATA_W-1:0]  read_value;
    logic                      found;
    logic [FPOS_W-1:0]         found_position;
    logic signed [DATA_W-1:0]  max_value;
    logic signed [DATA_W-1:0]  min_value;

    list_cmd_t      pending_cmds[$];
    list_result_t   expected_results[$];
    list_cmd_t      next_cmd;
    list_result_t   oldest_result;

    // shadow copy of the list
    logic signed [DATA_W-1:0]  list_words[LIST_DEPTH];
    int                        list_count = 0;

    int  error_count = 0;
    int  idle_cycles = 0;
    int  gen_count = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    bit  cmd_taken = 1'b0;

    indexed_list_store #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .position(position),
        .value(value),
        .done(done),
        .status(status),
        .count(count),
        .read_value(read_value),
        .found(found),
        .found_position(found_position),
        .max_value(max_value),
        .min_value(min_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // apply one command to the shadow list and return the word it produces
    function automatic list_result_t apply_list_action(input list_cmd_t cmd);
        list_result_t r;
        int n;
        logic signed [DATA_W-1:0] hi, lo;
        r = '0;
        r.status = ST_OK;
        r.max_value = -1;
        r.min_value = -1;
        case (cmd.action)
            ACT_READ:
            begin
                if (cmd.position < list_count)
                    r.read_value = list_words[cmd.position];
                else
                    r.status = ST_BADPOS;
            end
            ACT_INSERT:
            begin
                if (list_count >= LIST_DEPTH)
                    r.status = ST_FULL;
                else if (cmd.position > list_count)
                    r.status = ST_BADPOS;
                else
                begin
                    for (n = list_count; n > cmd.position; n--)
                        list_words[n] = list_words[n-1];
                    list_words[cmd.position] = cmd.value;
                    list_count++;
                end
            end
            ACT_DELETE:
            begin
                if (cmd.position >= list_count)
                    r.status = ST_BADPOS;
                else
                begin
                    for (n = cmd.position; n + 1 < list_count; n++)
                        list_words[n] = list_words[n+1];
                    list_count--;
                end
            end
            default:
            begin
                for (n = 0; n < list_count; n++)
                begin
                    if (!r.found && list_words[n] == cmd.value)
                    begin
                        r.found = 1'b1;
                        r.found_position = n[FPOS_W-1:0];
                    end
                end
            end
        endcase
        // extremes over the live entries
        if (list_count > 0)
        begin
            hi = list_words[0];
            lo = list_words[0];
            for (n = 1; n < list_count; n++)
            begin
                if (list_words[n] > hi)
                    hi = list_words[n];
                if (list_words[n] < lo)
                    lo = list_words[n];
            end
            r.max_value = hi;
            r.min_value = lo;
        end
        r.count = list_count[COUNT_W-1:0];
        return r;
    endfunction

    // queue a command and track the count it leaves behind
    task automatic queue_cmd(input logic [1:0] act, input int pos,
                             input logic signed [DATA_W-1:0] val);
        list_cmd_t c;
        c.action = act;
        c.position = pos[POS_IN_W-1:0];
        c.value = val;
        pending_cmds.push_back(c);
        if (act == ACT_INSERT && gen_count < LIST_DEPTH && c.position <= gen_count)
            gen_count++;
        else if (act == ACT_DELETE && c.position < gen_count)
            gen_count--;
    endtask

    // word mix: a small pool for repeats and hits, extremes, full random
    function automatic logic signed [DATA_W-1:0] draw_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom_range(0, 7) - 3;
        else if (pick == 5)
            return 32'sh8000_0000;
        else if (pick == 6)
            return 32'sh7fff_ffff;
        else
            return $urandom;
    endfunction

    task automatic check_result(input list_result_t want);
        if (status !== want.status)
            flag_error($sformatf("status got %0d want %0d", status, want.status));
        if (count !== want.count)
            flag_error($sformatf("count got %0d want %0d", count, want.count));
        if (read_value !== want.read_value)
            flag_error($sformatf("read_value got %0d want %0d",
                                 read_value, want.read_value));
        if (found !== want.found)
            flag_error($sformatf("found got %0d want %0d", found, want.found));
        if (found_position !== want.found_position)
            flag_error($sformatf("found_position got %0d want %0d",
                                 found_position, want.found_position));
        if (max_value !== want.max_value)
            flag_error($sformatf("max_value got %0d want %0d",
                                 max_value, want.max_value));
        if (min_value !== want.min_value)
            flag_error($sformatf("min_value got %0d want %0d",
                                 min_value, want.min_value));
    endtask

    // driver: new word at the falling edge, held until the block takes it
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !cmd_taken))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                action <= next_cmd.action;
                position <= next_cmd.position;
                value <= next_cmd.value;
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check result words, predict accepted commands, watchdog
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                flag_error("result word with none expected");
            else
            begin
                oldest_result = expected_results.pop_front();
                check_result(oldest_result);
            end
        end
        cmd_taken = rst_n && start && !busy;
        if (cmd_taken)
            expected_results.push_back(apply_list_action({action, position, value}));
        if (cmd_taken || (rst_n && done))
            idle_cycles = 0;
        else if (rst_n)
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int i, pos, phase_left, pick;
        bit growing;
        logic [1:0] act;

        // empty list corner cases
        queue_cmd(ACT_READ, 0, 0);
        queue_cmd(ACT_DELETE, 0, 0);
        queue_cmd(ACT_SEARCH, 0, 0);
        queue_cmd(ACT_INSERT, 1, 5);
        // extremes, append and front insert
        queue_cmd(ACT_INSERT, 0, 32'sh8000_0000);
        queue_cmd(ACT_INSERT, 1, 32'sh7fff_ffff);
        queue_cmd(ACT_INSERT, 0, -1);
        queue_cmd(ACT_READ, 2, 0);
        queue_cmd(ACT_READ, 31, 0);
        queue_cmd(ACT_SEARCH, 0, 32'sh7fff_ffff);
        queue_cmd(ACT_SEARCH, 0, 12345);
        queue_cmd(ACT_DELETE, 1, 0);
        queue_cmd(ACT_DELETE, 31, 0);
        // fill up with repeats, then the full list cases
        while (gen_count < LIST_DEPTH)
            queue_cmd(ACT_INSERT, gen_count / 2, 7);
        queue_cmd(ACT_INSERT, 0, 1);
        queue_cmd(ACT_INSERT, 31, 1);
        queue_cmd(ACT_SEARCH, 0, 7);
        queue_cmd(ACT_READ, LIST_DEPTH - 1, 0);
        queue_cmd(ACT_DELETE, LIST_DEPTH - 1, 0);

        // random part: alternating grow and shrink phases
        growing = 1'b0;
        phase_left = 0;
        for (i = 0; i < RANDOM_CMDS; i++)
        begin
            if (phase_left == 0)
            begin
                growing = !growing;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                act = growing ? ACT_INSERT : ACT_DELETE;
            else if (pick < 60)
                act = growing ? ACT_DELETE : ACT_INSERT;
            else if (pick < 80)
                act = ACT_READ;
            else
                act = ACT_SEARCH;
            if ($urandom_range(0, 99) < 12)
                pos = $urandom_range(0, 31);
            else if (act == ACT_INSERT)
                pos = $urandom_range(0, gen_count);
            else
                pos = $urandom_range(0, (gen_count > 0) ? gen_count - 1 : 0);
            queue_cmd(act, pos, draw_word());
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (LIST_DEPTH + 8) @(posedge clk);
        @(negedge clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d result words never arrived",
                                 expected_results.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
